### rtl/core/dca_pkg.sv
package dca_pkg;

    localparam int DEFAULT_OLD_DEPTH  = 4096;
    localparam int DEFAULT_COUNT_BITS = 16;

    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_DELTA = 2'd1,
        MODE_STEP  = 2'd2,
        MODE_END   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        PH_OPCODE    = 3'd0,
        PH_LEN_FIRST = 3'd1,
        PH_LEN_MORE  = 3'd2,
        PH_LITERAL   = 3'd3,
        PH_OFF_FIRST = 3'd4,
        PH_OFF_MORE  = 3'd5
    } t_phase;

    typedef struct packed {
        logic       byte_valid;
        logic       from_ram;
        logic       busy;
        logic       error;
        logic       done;
        logic [7:0] lit_byte;
    } t_res;

endpackage

### rtl/core/delta_copy_add_applier.sv
// Rebuilds a new file from an old file and a copy/add delta stream.
// Input beats carry a mode and a data byte: load an old-file byte, feed one
// delta byte, step one byte of a pending copy, or mark the end of the delta.
// Every input beat produces exactly one output beat, in order. The output beat
// carries a rebuilt byte with its valid flag, a busy flag for a delta byte that
// was refused while a copy is pending, the sticky error flag and the done flag.
// An accepted beat is held in the input register and is then decoded into
// the result register, which presents its result. One beat is accepted per
// cycle when the output side does not stall. Copy bytes come from the
// old-file store, read at the same edge that loads the result register, so
// a copy byte appears together with the rest of its result.
// When the receiver stalls, the result and the held store data stay put, the
// input register holds one more beat, and then o_stall is raised.
// Reset empties both registers and returns the parser to expect an opcode with
// the old length, error and end flags cleared; the store contents are kept.
module delta_copy_add_applier
    import dca_pkg::*;
#(
    parameter int OLD_DEPTH  = DEFAULT_OLD_DEPTH,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_busy_res,
    output logic       o_error,
    output logic       o_done_res
);

    localparam int AW = $clog2(OLD_DEPTH);

    logic       r_in_valid;
    t_mode      r_mode;
    logic [7:0] r_data;
    logic       r_out_valid;
    t_res       r_res;

    logic          in_take;
    logic          advance;
    t_res          res;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_q;

    assign advance = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode <= t_mode'(i_mode);
            r_data <= i_data;
        end
        if (advance) begin
            r_res <= res;
        end
    end

    dca_parser #(
        .OLD_DEPTH  (OLD_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (advance),
        .i_mode      (r_mode),
        .i_data      (r_data),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr)
    );

    dca_ram #(
        .WIDTH (8),
        .DEPTH (OLD_DEPTH)
    ) u_old_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign o_valid     = r_out_valid;
    assign o_out_byte  = r_res.from_ram ? ram_q : r_res.lit_byte;
    assign o_out_valid = r_res.byte_valid;
    assign o_busy_res  = r_res.busy;
    assign o_error     = r_res.error;
    assign o_done_res  = r_res.done;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Output beat presented right after reset.");

    a_byte_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> !o_busy_res)
        else $error("Rebuilt byte carried on a refused beat.");

    a_byte_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_valid) |-> !o_error)
        else $error("Rebuilt byte emitted with the error flag set.");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("Input stalled while the result register can move.");

endmodule

### rtl/core/dca_ram.sv
module dca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/dca_parser.sv
module dca_parser
    import dca_pkg::*;
#(
    parameter int OLD_DEPTH  = DEFAULT_OLD_DEPTH,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS,
    localparam int AW        = $clog2(OLD_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  t_mode         i_mode,
    input  logic [7:0]    i_data,
    output t_res          o_res,
    output logic          o_ram_we,
    output logic [AW-1:0] o_ram_waddr,
    output logic          o_ram_re,
    output logic [AW-1:0] o_ram_raddr
);

    localparam int LEN_W = $clog2(OLD_DEPTH + 1);
    localparam int OFW   = LEN_W + 4;
    localparam int LNW   = COUNT_BITS + 4;
    localparam int SUM_W = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 1;

    logic [LEN_W-1:0]      r_old_len, n_old_len;
    t_phase                r_phase, n_phase;
    logic                  r_is_copy, n_is_copy;
    logic [COUNT_BITS-1:0] r_len, n_len;
    logic [LEN_W-1:0]      r_off, n_off;
    logic [LEN_W-1:0]      r_ptr, n_ptr;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic                  r_err, n_err;
    logic                  r_ended, n_ended;

    logic             is_digit;
    logic [3:0]       dval;
    logic [LNW-1:0]   len_next;
    logic             len_ovf;
    logic [OFW-1:0]   off_next;
    logic             off_ovf;
    logic             copy_bad;
    logic             is_a;
    logic             is_c;
    logic             raise;

    assign is_digit = (i_data >= CH_ZERO) && (i_data <= CH_NINE);
    assign dval     = 4'(i_data - CH_ZERO);
    assign len_next = LNW'({r_len, 3'b000}) + LNW'({r_len, 1'b0}) + LNW'(dval);
    assign len_ovf  = |len_next[LNW-1:COUNT_BITS];
    assign off_next = OFW'({r_off, 3'b000}) + OFW'({r_off, 1'b0}) + OFW'(dval);
    assign off_ovf  = off_next > OFW'(OLD_DEPTH);
    assign copy_bad = (SUM_W'(r_off) + SUM_W'(r_len)) > SUM_W'(r_old_len);
    assign is_a     = i_data == CH_A;
    assign is_c     = i_data == CH_C;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_len <= '0;
            r_phase   <= PH_OPCODE;
            r_is_copy <= 1'b0;
            r_len     <= '0;
            r_off     <= '0;
            r_ptr     <= '0;
            r_rem     <= '0;
            r_err     <= 1'b0;
            r_ended   <= 1'b0;
        end else if (i_go) begin
            r_old_len <= n_old_len;
            r_phase   <= n_phase;
            r_is_copy <= n_is_copy;
            r_len     <= n_len;
            r_off     <= n_off;
            r_ptr     <= n_ptr;
            r_rem     <= n_rem;
            r_err     <= n_err;
            r_ended   <= n_ended;
        end
    end

    always_comb begin
        n_old_len = r_old_len;
        n_phase   = r_phase;
        n_is_copy = r_is_copy;
        n_len     = r_len;
        n_off     = r_off;
        n_ptr     = r_ptr;
        n_rem     = r_rem;
        n_err     = r_err;
        n_ended   = r_ended;
        raise     = 1'b0;
        o_res     = '0;
        o_ram_we  = 1'b0;
        o_ram_re  = 1'b0;

        case (i_mode)
            MODE_LOAD: begin
                if (r_old_len < LEN_W'(OLD_DEPTH)) begin
                    o_ram_we  = i_go;
                    n_old_len = r_old_len + LEN_W'(1);
                end
            end
            MODE_DELTA: begin
                if (!r_err && !r_ended) begin
                    if (r_rem != '0) begin
                        o_res.busy = 1'b1;
                    end else begin
                        case (r_phase)
                            PH_OPCODE: begin
                                if (is_a || is_c) begin
                                    n_is_copy = is_c;
                                    n_len     = '0;
                                    n_off     = '0;
                                    n_phase   = PH_LEN_FIRST;
                                end else begin
                                    raise = 1'b1;
                                end
                            end
                            PH_LEN_FIRST, PH_LEN_MORE: begin
                                if (is_digit) begin
                                    if (len_ovf) begin
                                        raise = 1'b1;
                                    end else begin
                                        n_len   = len_next[COUNT_BITS-1:0];
                                        n_phase = PH_LEN_MORE;
                                    end
                                end else if (r_phase == PH_LEN_FIRST) begin
                                    raise = 1'b1;
                                end else if (r_is_copy) begin
                                    n_phase = PH_OFF_FIRST;
                                end else if (r_len == '0) begin
                                    n_phase = PH_OPCODE;
                                end else begin
                                    n_phase = PH_LITERAL;
                                end
                            end
                            PH_LITERAL: begin
                                o_res.byte_valid = 1'b1;
                                o_res.lit_byte   = i_data;
                                n_len            = r_len - COUNT_BITS'(1);
                                if (r_len == COUNT_BITS'(1)) begin
                                    n_phase = PH_OPCODE;
                                end
                            end
                            PH_OFF_FIRST, PH_OFF_MORE: begin
                                if (is_digit) begin
                                    if (off_ovf) begin
                                        raise = 1'b1;
                                    end else begin
                                        n_off   = off_next[LEN_W-1:0];
                                        n_phase = PH_OFF_MORE;
                                    end
                                end else if (r_phase == PH_OFF_FIRST) begin
                                    raise = 1'b1;
                                end else if (copy_bad) begin
                                    raise = 1'b1;
                                end else begin
                                    n_ptr = r_off;
                                    n_rem = r_len;
                                    if (is_a || is_c) begin
                                        n_is_copy = is_c;
                                        n_len     = '0;
                                        n_off     = '0;
                                        n_phase   = PH_LEN_FIRST;
                                    end else begin
                                        raise = 1'b1;
                                    end
                                end
                            end
                            default: begin
                                raise = 1'b1;
                            end
                        endcase
                    end
                end
            end
            MODE_STEP: begin
                if (!r_err && (r_rem != '0)) begin
                    o_ram_re         = i_go;
                    o_res.byte_valid = 1'b1;
                    o_res.from_ram   = 1'b1;
                    n_ptr            = r_ptr + LEN_W'(1);
                    n_rem            = r_rem - COUNT_BITS'(1);
                end
            end
            MODE_END: begin
                if (!r_err && !r_ended) begin
                    if (r_phase == PH_OFF_MORE) begin
                        if (copy_bad) begin
                            raise = 1'b1;
                        end else begin
                            n_ptr   = r_off;
                            n_rem   = r_len;
                            n_phase = PH_OPCODE;
                        end
                    end else if (r_phase != PH_OPCODE) begin
                        raise = 1'b1;
                    end
                end
                n_ended = 1'b1;
            end
            default: begin
            end
        endcase

        if (raise) begin
            n_err   = 1'b1;
            n_rem   = '0;
            n_phase = PH_OPCODE;
        end

        o_res.error = n_err;
        o_res.done  = n_ended && (n_rem == '0);
    end

    assign o_ram_waddr = r_old_len[AW-1:0];
    assign o_ram_raddr = r_ptr[AW-1:0];

endmodule

### tb/rebuild_monitor.sv
`timescale 1ns / 1ps

module rebuild_monitor
    import dca_pkg::*;
#(
    parameter int OLD_DEPTH  = DEFAULT_OLD_DEPTH,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_mode,
    input  logic [7:0] i_data,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_byte_valid,
    input  logic       i_busy_res,
    input  logic       i_error,
    input  logic       i_done_res,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_beats_in,
    output int         o_checked,
    output int         o_rebuilt,
    output int         o_refused
);

    localparam int OFF_W     = $clog2(OLD_DEPTH + 1);
    localparam int IDX_W     = $clog2(OLD_DEPTH);
    localparam int LEN_ACC_W = COUNT_BITS + 4;
    localparam int OFF_ACC_W = OFF_W + 4;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       busy;
        logic       error;
        logic       done;
    } t_rebuilt_beat;

    logic [7:0]            old_bytes [OLD_DEPTH];
    logic [OFF_W-1:0]      old_len;
    logic [OFF_W-1:0]      off_acc;
    logic [OFF_W-1:0]      copy_ptr;
    logic [COUNT_BITS-1:0] len_acc;
    logic [COUNT_BITS-1:0] copy_left;
    t_phase                parse_ph;
    logic                  op_copy;
    logic                  err_seen;
    logic                  end_seen;
    t_rebuilt_beat         expected_beats [$];

    function automatic logic is_digit(logic [7:0] d);
        return d >= CH_ZERO && d <= CH_NINE;
    endfunction

    function automatic void raise_error();
        err_seen  = 1'b1;
        copy_left = '0;
        parse_ph  = PH_OPCODE;
    endfunction

    function automatic void take_opcode(logic [7:0] d);
        if (d == CH_A) begin
            op_copy = 1'b0;
        end else if (d == CH_C) begin
            op_copy = 1'b1;
        end else begin
            raise_error();
            return;
        end
        len_acc  = '0;
        off_acc  = '0;
        parse_ph = PH_LEN_FIRST;
    endfunction

    function automatic void start_copy();
        int unsigned span;
        span = 32'(off_acc);
        span = span + 32'(len_acc);
        if (span > old_len) begin
            raise_error();
        end else begin
            copy_ptr  = off_acc;
            copy_left = len_acc;
            parse_ph  = PH_OPCODE;
        end
    endfunction

    function automatic void add_len_digit(logic [7:0] d);
        logic [LEN_ACC_W-1:0] next_len;
        next_len = LEN_ACC_W'(len_acc * 10 + (d - CH_ZERO));
        if (next_len > {COUNT_BITS{1'b1}}) begin
            raise_error();
        end else begin
            len_acc  = next_len[COUNT_BITS-1:0];
            parse_ph = PH_LEN_MORE;
        end
    endfunction

    function automatic void add_off_digit(logic [7:0] d);
        logic [OFF_ACC_W-1:0] next_off;
        next_off = OFF_ACC_W'(off_acc * 10 + (d - CH_ZERO));
        if (next_off > OLD_DEPTH) begin
            raise_error();
        end else begin
            off_acc  = next_off[OFF_W-1:0];
            parse_ph = PH_OFF_MORE;
        end
    endfunction

    // Returns 1 when the delta byte is passed through as a literal.
    function automatic logic take_delta(logic [7:0] d);
        case (parse_ph)
            PH_OPCODE: begin
                take_opcode(d);
            end
            PH_LEN_FIRST: begin
                if (is_digit(d)) add_len_digit(d);
                else raise_error();
            end
            PH_LEN_MORE: begin
                if (is_digit(d)) begin
                    add_len_digit(d);
                end else if (op_copy) begin
                    parse_ph = PH_OFF_FIRST;
                end else begin
                    parse_ph = (len_acc == 0) ? PH_OPCODE : PH_LITERAL;
                end
            end
            PH_LITERAL: begin
                len_acc = len_acc - 1'b1;
                if (len_acc == 0) parse_ph = PH_OPCODE;
                return 1'b1;
            end
            PH_OFF_FIRST: begin
                if (is_digit(d)) add_off_digit(d);
                else raise_error();
            end
            PH_OFF_MORE: begin
                if (is_digit(d)) begin
                    add_off_digit(d);
                end else begin
                    start_copy();
                    if (!err_seen) take_opcode(d);
                end
            end
            default: begin
                raise_error();
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_rebuilt_beat predict_beat(t_mode m, logic [7:0] d);
        t_rebuilt_beat r;
        r = '0;
        case (m)
            MODE_LOAD: begin
                if (old_len < OLD_DEPTH) begin
                    old_bytes[old_len[IDX_W-1:0]] = d;
                    old_len = old_len + 1'b1;
                end
            end
            MODE_DELTA: begin
                if (!err_seen && !end_seen) begin
                    if (copy_left != 0) begin
                        r.busy = 1'b1;
                    end else if (take_delta(d)) begin
                        r.out_valid = 1'b1;
                        r.out_byte  = d;
                    end
                end
            end
            MODE_STEP: begin
                if (!err_seen && copy_left != 0) begin
                    if (copy_ptr < OLD_DEPTH) r.out_byte = old_bytes[copy_ptr[IDX_W-1:0]];
                    r.out_valid = 1'b1;
                    copy_ptr    = copy_ptr + 1'b1;
                    copy_left   = copy_left - 1'b1;
                end
            end
            default: begin
                if (!err_seen && !end_seen) begin
                    if (parse_ph == PH_OFF_MORE) start_copy();
                    else if (parse_ph != PH_OPCODE) raise_error();
                end
                end_seen = 1'b1;
            end
        endcase
        r.error = err_seen;
        r.done  = end_seen && copy_left == 0;
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_rebuilt_beat want;
        if (!i_rst_n) begin
            old_len   = '0;
            off_acc   = '0;
            copy_ptr  = '0;
            len_acc   = '0;
            copy_left = '0;
            parse_ph  = PH_OPCODE;
            op_copy   = 1'b0;
            err_seen  = 1'b0;
            end_seen  = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_beats.push_back(predict_beat(t_mode'(i_mode), i_data));
                o_beats_in++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_beats.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat with nothing expected, byte %0h valid %0b",
                             $time, i_out_byte, i_out_byte_valid);
                end else begin
                    want = expected_beats.pop_front();
                    o_checked++;
                    if (want.out_valid) o_rebuilt++;
                    if (want.busy) o_refused++;
                    check_field("out_byte", want.out_byte, i_out_byte);
                    check_field("out_valid", 8'(want.out_valid), 8'(i_out_byte_valid));
                    check_field("busy_res", 8'(want.busy), 8'(i_busy_res));
                    check_field("error", 8'(want.error), 8'(i_error));
                    check_field("done_res", 8'(want.done), 8'(i_done_res));
                end
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dca_pkg::*;

    localparam int OLD_DEPTH      = DEFAULT_OLD_DEPTH;
    localparam int WATCHDOG_LIMIT = 4000;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_stall = 1'b0;
    logic [1:0] i_mode  = MODE_LOAD;
    logic [7:0] i_data  = 8'h00;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic       o_busy_res;
    logic       o_error;
    logic       o_done_res;

    int    fail_count;
    int    pending;
    int    beats_in;
    int    checked;
    int    rebuilt;
    int    refused;
    int    src_idle_pct   = 21;
    int    sink_stall_pct = 88;
    int    sent_beats     = 0;
    int    old_fill       = 0;
    int    copy_due       = 0;
    int    idle_cycles    = 0;
    string closing_case;

    delta_copy_add_applier u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_out_valid(o_out_valid),
        .o_busy_res (o_busy_res),
        .o_error    (o_error),
        .o_done_res (o_done_res)
    );

    rebuild_monitor u_rebuild_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_mode          (i_mode),
        .i_data          (i_data),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_byte      (o_out_byte),
        .i_out_byte_valid(o_out_valid),
        .i_busy_res      (o_busy_res),
        .i_error         (o_error),
        .i_done_res      (o_done_res),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_in      (beats_in),
        .o_checked       (checked),
        .o_rebuilt       (rebuilt),
        .o_refused       (refused)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_beat(t_mode m, logic [7:0] d);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= m;
        i_data  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_beats++;
    endtask

    task automatic load_old(logic [7:0] d);
        send_beat(MODE_LOAD, d);
        if (old_fill < OLD_DEPTH) old_fill++;
    endtask

    task automatic send_step();
        send_beat(MODE_STEP, rand_byte());
    endtask

    function automatic logic [7:0] pick_separator();
        logic [7:0] s;
        do s = rand_byte();
        while (s >= CH_ZERO && s <= CH_NINE);
        return s;
    endfunction

    // A started copy refuses delta bytes, so every copy byte is stepped out
    // before the parse continues; a refused byte is sometimes slipped in.
    task automatic drain_copy();
        repeat (copy_due) begin
            if ($urandom_range(0, 3) == 0) send_beat(MODE_DELTA, rand_byte());
            if ($urandom_range(0, 7) == 0) load_old(rand_byte());
            send_step();
        end
        if ($urandom_range(0, 4) == 0) send_step();
        copy_due = 0;
    endtask

    task automatic send_opcode(logic [7:0] op);
        send_beat(MODE_DELTA, op);
        drain_copy();
    endtask

    task automatic send_number(int unsigned value);
        int unsigned digits [$];
        int unsigned rest;
        rest = value;
        do begin
            digits.push_front(rest % 10);
            rest = rest / 10;
        end while (rest != 0);
        if ($urandom_range(0, 5) == 0) digits.push_front(0);
        foreach (digits[k]) send_beat(MODE_DELTA, 8'(CH_ZERO + digits[k]));
    endtask

    task automatic add_cmd(int unsigned n);
        send_opcode(CH_A);
        send_number(n);
        send_beat(MODE_DELTA, pick_separator());
    endtask

    task automatic copy_cmd(int unsigned n, int unsigned off);
        send_opcode(CH_C);
        send_number(n);
        send_beat(MODE_DELTA, pick_separator());
        send_number(off);
        copy_due = n;
    endtask

    task automatic random_instruction();
        int unsigned n;
        int unsigned off;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 5);
                add_cmd(n);
                repeat (n) send_beat(MODE_DELTA, rand_byte());
            end
            4, 5, 6, 7: begin
                n   = $urandom_range(0, (old_fill < 12) ? old_fill : 12);
                off = $urandom_range(0, old_fill - n);
                copy_cmd(n, off);
            end
            8: begin
                repeat ($urandom_range(1, 3)) load_old(rand_byte());
            end
            default: begin
                send_step();
            end
        endcase
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int beat_target);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent_beats < beat_target) random_instruction();
        wait_drained();
    endtask

    task automatic close_delta();
        int unsigned n;
        logic [7:0]  bad;
        case ($urandom_range(0, 8))
            0: begin
                closing_case = "a bad opcode";
                do bad = rand_byte();
                while (bad == CH_A || bad == CH_C || (bad >= CH_ZERO && bad <= CH_NINE));
                send_opcode(bad);
            end
            1: begin
                closing_case = "missing length digits";
                send_opcode($urandom_range(0, 1) ? CH_A : CH_C);
                send_beat(MODE_DELTA, pick_separator());
            end
            2: begin
                closing_case = "missing offset digits";
                send_opcode(CH_C);
                send_number(1);
                send_beat(MODE_DELTA, pick_separator());
                send_beat(MODE_DELTA, pick_separator());
            end
            3: begin
                closing_case = "a length overflow";
                send_opcode($urandom_range(0, 1) ? CH_A : CH_C);
                send_number($urandom_range(1 << DEFAULT_COUNT_BITS, 99999));
            end
            4: begin
                closing_case = "an offset overflow";
                send_opcode(CH_C);
                send_number($urandom_range(0, 9));
                send_beat(MODE_DELTA, pick_separator());
                send_number($urandom_range(OLD_DEPTH + 1, 9999));
            end
            5: begin
                closing_case = "a copy past the old length";
                n = $urandom_range(1, 4);
                copy_cmd(n, old_fill - n + $urandom_range(1, n));
                send_opcode(CH_A);
            end
            6: begin
                closing_case = "a truncated add";
                add_cmd(3);
                send_beat(MODE_DELTA, rand_byte());
                send_beat(MODE_END, rand_byte());
            end
            7: begin
                closing_case = "an end that completes a pending offset";
                copy_cmd(4, $urandom_range(0, old_fill - 4));
                send_beat(MODE_END, rand_byte());
                drain_copy();
            end
            default: begin
                closing_case = "an end inside the opcode after a copy";
                copy_cmd(2, $urandom_range(0, old_fill - 2));
                send_beat(MODE_DELTA, CH_A);
                send_beat(MODE_END, rand_byte());
                drain_copy();
            end
        endcase
        send_beat(MODE_END, rand_byte());
        repeat (4) begin
            send_beat(MODE_DELTA, rand_byte());
            send_step();
        end
        load_old(rand_byte());
        send_beat(MODE_END, rand_byte());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_old(8'h00);
        load_old(8'hFF);
        load_old(8'h55);
        load_old(8'hAA);
        send_step();
        add_cmd(0);
        add_cmd(2);
        send_beat(MODE_DELTA, 8'h00);
        send_beat(MODE_DELTA, 8'hFF);
        copy_cmd(0, 4);
        copy_cmd(3, 1);
        send_beat(MODE_DELTA, CH_A);
        send_beat(MODE_DELTA, CH_NINE);
        drain_copy();
        send_number(1);
        send_beat(MODE_DELTA, pick_separator());
        send_beat(MODE_DELTA, 8'h80);

        run_phase(21, 88, 180);
        run_phase(88, 21, 350);
        run_phase(0, 0, 520);

        load_old(rand_byte());
        copy_cmd(4, old_fill - 4);
        copy_cmd(0, old_fill);
        close_delta();

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d input beats and %0d results: %0d rebuilt bytes, %0d busy refusals.",
                 beats_in, checked, rebuilt, refused);
        $display("Copies reached the top of the loaded old bytes and the delta closed with %s.",
                 closing_case);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
